[hdl/rmst_pkg.sv]
package rmst_pkg;
  localparam int unsigned Leaves    = 1024;
  localparam int unsigned ValueBits = 16;
  localparam int unsigned PosBits   = 10;
  localparam int unsigned RangeBits = 11;
  localparam int unsigned NodeBits  = PosBits + 1;
  localparam int unsigned Nodes     = 2 * Leaves;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeQuery = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [PosBits-1:0]   position;
    logic [ValueBits-1:0] value;
    logic [RangeBits-1:0] range_low;
    logic [RangeBits-1:0] range_high;
  } req_t;

  typedef struct packed {
    logic [ValueBits-1:0] max_value;
  } rsp_t;
endpackage

[hdl/rmst_if.sv]
interface rmst_req_if import rmst_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rmst_rsp_if import rmst_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/range_max_segment_tree.sv]
// range max segment tree over 1024 leaves of 16 bits
// req_i: valid/ready request channel, payload mode/position/value/range_low/range_high
//   mode write stores value at leaf position and refreshes all ancestors
//   mode query returns the max over [range_low, range_high), 0 when empty
// rsp_o: one response per query, none for writes
// all nodes sit in one single-port memory with a registered read.
// a write stores the leaf, then writes each parent the max of its two children,
// a query climbs level by level and reads each boundary node that it takes in;
// one request is worked at a time
// after reset a clearing pass zeroes every node of the memory, with ready low
// a finished response waits in an output register; the next request is taken
// while it waits, and a new response only waits for that register to empty
module range_max_segment_tree import rmst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rmst_req_if.sink   req_i,
  rmst_rsp_if.source rsp_o
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WLEAF, S_WRD0, S_WRD1, S_WRD2, S_WWR,
    S_QSTEP, S_QRDL, S_QRDR, S_QWAIT, S_QSHIFT, S_QDONE
  } state_e;

  logic [ValueBits-1:0] mem_q [Nodes];
  logic [ValueBits-1:0] rdata_q;
  logic                 ren, wen;
  logic [NodeBits-1:0]  addr;
  logic [ValueBits-1:0] wdata;

  state_e               state_q;
  logic [NodeBits-1:0]  n_q;
  logic [NodeBits:0]    l_q, r_q;
  logic [ValueBits-1:0] a_q, best_q, val_q;
  logic                 rvld_q;
  logic [ValueBits-1:0] rmax_q;
  logic                 pend_q; // read of right node issued in QRDR

  always_ff @(posedge clk_i) begin
    if (wen) mem_q[addr] <= wdata;
    if (ren) rdata_q <= mem_q[addr];
  end

  always_comb begin
    ren   = 1'b0;
    wen   = 1'b0;
    addr  = n_q;
    wdata = val_q;
    case (state_q)
      S_CLEAR: begin
        wen = 1'b1;
        wdata = '0;
      end
      S_WLEAF: wen = 1'b1;
      S_WRD0: begin
        ren = 1'b1;
        addr = {n_q[NodeBits-2:0], 1'b0};
      end
      S_WRD1: begin
        ren = 1'b1;
        addr = {n_q[NodeBits-2:0], 1'b1};
      end
      S_WWR: begin
        wen = 1'b1;
        wdata = (a_q > rdata_q) ? a_q : rdata_q;
      end
      S_QRDL: begin
        ren = 1'b1;
        addr = l_q[NodeBits-1:0];
      end
      S_QRDR: begin
        ren = 1'b1;
        addr = r_q[NodeBits-1:0] - 1'b1;
      end
      default: ;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rvld_q;
  assign rsp_o.payload.max_value = rmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      n_q     <= '0;
      l_q     <= '0;
      r_q     <= '0;
      a_q     <= '0;
      best_q  <= '0;
      val_q   <= '0;
      rvld_q  <= 1'b0;
      rmax_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (rvld_q && rsp_o.ready && state_q != S_QDONE) rvld_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          n_q <= n_q + 1'b1;
          if (n_q == NodeBits'(Nodes - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req_i.valid) begin
            if (req_i.payload.mode == ModeWrite) begin
              n_q   <= {1'b1, req_i.payload.position};
              val_q <= req_i.payload.value;
              state_q <= S_WLEAF;
            end else begin
              best_q <= '0;
              l_q <= {1'b0, req_i.payload.range_low} + (NodeBits+1)'(Leaves);
              if (req_i.payload.range_high > RangeBits'(Leaves))
                r_q <= (NodeBits+1)'(2 * Leaves);
              else
                r_q <= {1'b0, req_i.payload.range_high} + (NodeBits+1)'(Leaves);
              if (req_i.payload.range_low < req_i.payload.range_high)
                state_q <= S_QSTEP;
              else
                state_q <= S_QDONE;
            end
          end
        end
        S_WLEAF: begin
          n_q <= n_q >> 1;
          state_q <= (n_q == NodeBits'(1)) ? S_IDLE : S_WRD0;
        end
        S_WRD0: state_q <= S_WRD1;
        S_WRD1: begin
          a_q <= rdata_q;
          state_q <= S_WRD2;
        end
        S_WRD2: state_q <= S_WWR;
        S_WWR: begin
          val_q <= wdata;
          n_q <= n_q >> 1;
          state_q <= (n_q == NodeBits'(1)) ? S_IDLE : S_WRD0;
        end
        S_QSTEP: begin
          if (l_q >= r_q) state_q <= S_QDONE;
          else if (l_q[0]) state_q <= S_QRDL;
          else if (r_q[0]) state_q <= S_QRDR;
          else state_q <= S_QSHIFT;
        end
        S_QRDL: begin
          pend_q <= 1'b0;
          state_q <= S_QWAIT;
        end
        S_QRDR: begin
          pend_q <= 1'b1;
          state_q <= S_QWAIT;
        end
        S_QWAIT: begin
          if (rdata_q > best_q) best_q <= rdata_q;
          if (pend_q) begin
            r_q <= r_q - 1'b1;
            state_q <= S_QSHIFT;
          end else begin
            l_q <= l_q + 1'b1;
            state_q <= r_q[0] ? S_QRDR : S_QSHIFT;
          end
        end
        S_QSHIFT: begin
          l_q <= l_q >> 1;
          r_q <= r_q >> 1;
          state_q <= S_QSTEP;
        end
        S_QDONE: begin
          if (!rvld_q || rsp_o.ready) begin
            rvld_q <= 1'b1;
            rmax_q <= best_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
